// ===== hdl/gap_buffer_editor_defines.svh =====
// Assertion macros shared by the gap buffer editor checkers.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef GAP_BUFFER_EDITOR_DEFINES_SVH
`define GAP_BUFFER_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gbe_pkg.sv =====
// Shared types and codes for the gap buffer editor.
// No dependencies.
`timescale 1ns / 1ps

package gbe_pkg;

    localparam int CAPACITY   = 1024;
    localparam int CHAR_WIDTH = 8;

    localparam int OP_W     = 2;
    localparam int POS_W    = 11;
    localparam int COUNT_W  = 11;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_READ    = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE   = 2'd2;
    localparam logic [OP_W-1:0] OP_REPLACE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] remove_count;
        logic [COUNT_W-1:0] fill_count;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [POS_W-1:0]    length;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

// ===== hdl/gap_buffer_editor.sv =====
// Gap buffer editor: a read goes through check, read and done before its result word is valid;
// a range or capacity error goes from check straight to done. An edit runs check, gap move,
// erase, fill and done; the gap move and fill each take one store port access a cycle.
// One request in flight; the next word is taken while the previous result waits.
// Reset: length 0, gap covers the whole store; store contents are not cleared.
// Top level; depends on gbe_pkg, gbe_core and gbe_out_slot.
`timescale 1ns / 1ps

module gap_buffer_editor #(
    parameter int CAPACITY   = gbe_pkg::CAPACITY,
    parameter int CHAR_WIDTH = gbe_pkg::CHAR_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gbe_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output gbe_pkg::rsp_t rsp
);

    logic          push;
    logic          push_ok;
    gbe_pkg::rsp_t push_data;

    gbe_core #(
        .CAPACITY   (CAPACITY),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .push_ok   (push_ok),
        .push      (push),
        .rsp       (push_data)
    );

    gbe_out_slot u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .push_ok   (push_ok),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/gbe_core.sv =====
// Request sequencer and character store of the gap buffer editor.
// Depends on gbe_pkg.
`timescale 1ns / 1ps

module gbe_core #(
    parameter int CAPACITY   = gbe_pkg::CAPACITY,
    parameter int CHAR_WIDTH = gbe_pkg::CHAR_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gbe_pkg::req_t req,
    input  logic          push_ok,
    output logic          push,
    output gbe_pkg::rsp_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = ((PW > gbe_pkg::POS_W) ? PW : gbe_pkg::POS_W) + 1;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MOVE  = 3'd3;
    localparam logic [2:0] ST_ERASE = 3'd4;
    localparam logic [2:0] ST_FILL  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [PW-1:0]                  gs_reg, gs_next;
    logic [PW-1:0]                  ge_reg, ge_next;
    gbe_pkg::req_t                  req_reg, req_next;
    logic [PW-1:0]                  target_reg, target_next;
    logic [PW-1:0]                  rem_reg, rem_next;
    logic [gbe_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [gbe_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [gbe_pkg::VALUE_W-1:0]    rd_reg, rd_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [AW-1:0]                  pend_addr_reg, pend_addr_next;

    logic [CHAR_WIDTH-1:0] char_store [CAPACITY];
    logic [CHAR_WIDTH-1:0] rdata_reg;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [CHAR_WIDTH-1:0] mem_wdata;

    logic [PW-1:0]                  len, glen;
    logic [CW-1:0]                  len_x, pos_x, rem_x, fill_x;
    logic [PW-1:0]                  rd_addr;

    assign len   = gs_reg + (CAP_P - ge_reg);
    assign glen  = ge_reg - gs_reg;
    assign len_x = CW'(len);
    assign pos_x = CW'(req_reg.position);
    assign rem_x = (req_reg.operation == gbe_pkg::OP_INSERT) ? '0 : CW'(req_reg.remove_count);
    assign fill_x = (req_reg.operation == gbe_pkg::OP_ERASE) ? '0 : CW'(req_reg.fill_count);
    // logical position to store index: skip the gap when at or past gap start
    assign rd_addr = (PW'(pos_x) < gs_reg) ? PW'(pos_x) : PW'(pos_x) + glen;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        gs_next         = gs_reg;
        ge_next         = ge_reg;
        req_next        = req_reg;
        target_next     = target_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        // a gap-move read lands in the next cycle and is written back here
        mem_we          = pend_valid_reg;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = rdata_reg;
        push            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                rd_next     = '0;
                status_next = gbe_pkg::STATUS_OK;
                if (req_reg.operation == gbe_pkg::OP_READ)
                begin
                    if (pos_x >= len_x)
                    begin
                        status_next = gbe_pkg::STATUS_RANGE;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(rd_addr);
                        state_next = ST_READ;
                    end
                end
                else if (pos_x > len_x || pos_x + rem_x > len_x)
                begin
                    status_next = gbe_pkg::STATUS_RANGE;
                    state_next  = ST_DONE;
                end
                else if (len_x + fill_x > CAP_C + rem_x)
                begin
                    status_next = gbe_pkg::STATUS_CAPACITY;
                    state_next  = ST_DONE;
                end
                else
                begin
                    target_next = PW'(pos_x + rem_x);
                    rem_next    = PW'(rem_x);
                    cnt_next    = gbe_pkg::COUNT_W'(fill_x);
                    state_next  = ST_MOVE;
                end
            end
            ST_READ:
            begin
                rd_next    = gbe_pkg::VALUE_W'(rdata_reg);
                state_next = ST_DONE;
            end
            ST_MOVE:
            begin
                if (gs_reg == target_reg)
                begin
                    state_next = ST_ERASE;
                end
                else if (gs_reg > target_reg)
                begin
                    // shift the character just before the gap to its end
                    mem_re          = 1'b1;
                    mem_raddr       = AW'(gs_reg - PW'(1));
                    pend_valid_next = 1'b1;
                    pend_addr_next  = AW'(ge_reg - PW'(1));
                    gs_next         = gs_reg - PW'(1);
                    ge_next         = ge_reg - PW'(1);
                end
                else
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = AW'(ge_reg);
                    pend_valid_next = 1'b1;
                    pend_addr_next  = AW'(gs_reg);
                    gs_next         = gs_reg + PW'(1);
                    ge_next         = ge_reg + PW'(1);
                end
            end
            ST_ERASE:
            begin
                gs_next    = gs_reg - rem_reg;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(gs_reg);
                    mem_wdata = CHAR_WIDTH'(req_reg.value);
                    gs_next   = gs_reg + PW'(1);
                    cnt_next  = cnt_reg - gbe_pkg::COUNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (push_ok)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.read_value = rd_reg;
    assign rsp.length     = gbe_pkg::POS_W'(len);
    assign rsp.status     = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gs_reg         <= '0;
            ge_reg         <= CAP_P;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gs_reg         <= gs_next;
            ge_reg         <= ge_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        target_reg    <= target_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        status_reg    <= status_next;
        rd_reg        <= rd_next;
        pend_addr_reg <= pend_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            char_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= char_store[mem_raddr];
        end
    end

endmodule

// ===== hdl/gbe_out_slot.sv =====
// Output register for result words of the gap buffer editor.
// Depends on gbe_pkg.
`timescale 1ns / 1ps

module gbe_out_slot (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbe_pkg::rsp_t push_data,
    output logic          push_ok,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output gbe_pkg::rsp_t rsp
);

    logic          valid_reg, valid_next;
    gbe_pkg::rsp_t data_reg, data_next;

    assign push_ok   = !valid_reg || rsp_ready;
    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (push)
        begin
            valid_next = 1'b1;
            data_next  = push_data;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hdl/gbe_checker.sv =====
// Port-level assertions for the gap buffer editor, bound to the top level.
// Depends on gbe_pkg and gap_buffer_editor_defines.svh.
`timescale 1ns / 1ps
`include "gap_buffer_editor_defines.svh"

module gbe_checker #(
    parameter int CAPACITY = gbe_pkg::CAPACITY
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input gbe_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input gbe_pkg::rsp_t rsp
);

    // a waiting request word holds
    `GBE_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req), "req moved")

    // a stalled result word holds
    `GBE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp moved")

    // one request at a time: no second word right after an accept
    `GBE_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready, "accepted while busy")

    `GBE_ASSERT_NOW(a_len_bound, rsp_valid, rsp.length <= CAPACITY, "length beyond capacity")

    `GBE_ASSERT_NOW(a_err_zero, rsp_valid && rsp.status != '0, rsp.read_value == '0, "read on error")

endmodule

bind gap_buffer_editor gbe_checker #(
    .CAPACITY (CAPACITY)
) u_gbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
